// ===== hdl/vfs_pkg.sv =====
// ---------------------------------------------------------------------------
// vfs_pkg: shared types and constants of the volume flow statistics unit
// Field widths, register codes, queue entry, iterative unit request and
// back-end sequencer states.
// ---------------------------------------------------------------------------
package vfs_pkg;

    // fixed point and counter limits
    localparam int FRAC_BITS   = 16;
    localparam int MAX_CELLS   = 2097152;
    localparam int CNT_W       = 22;
    localparam int CNT_LIMIT   = (MAX_CELLS < 4194303) ? MAX_CELLS : 4194303;
    localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(CNT_LIMIT);
    localparam int UNIT_W      = 18;
    localparam int WT_W        = 52;
    localparam logic [WT_W-1:0] WT_CAP = {WT_W{1'b1}};

    // stream widths
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 176;

    // configuration register codes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_DIR_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_DIR_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_DIR_Z  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd4;

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    // shared square root / divide unit
    localparam int ITER_CNT_W = 7;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 64;

    typedef struct packed {
        logic               up_enable;
        logic signed [31:0] up_dir_x;
        logic signed [31:0] up_dir_y;
        logic signed [31:0] up_dir_z;
        logic [15:0]        threshold;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] density;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic               solid;
        logic               active;
        logic               last;
    } voxel_t;

    typedef enum logic {
        ITER_SQRT,
        ITER_DIV
    } iter_op_t;

    typedef struct packed {
        logic        start;
        iter_op_t    op;
        logic [63:0] a;
        logic [WT_W-1:0] b;
    } iter_req_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_AX_MUL,
        BK_AX_SQRT,
        BK_AX_DIV,
        BK_V_MUL,
        BK_V_SQRT,
        BK_P_MUL,
        BK_P_FIN,
        BK_PD_MUL,
        BK_PD_ACC,
        BK_END,
        BK_M_DIV,
        BK_EMIT
    } back_state_t;

endpackage

// ===== hdl/vfs_front.sv =====
// ---------------------------------------------------------------------------
// vfs_front: input stage
// Takes voxel words from the slave stream, classifies them against the
// activity threshold and hands them to the queue.
// ---------------------------------------------------------------------------
module vfs_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [vfs_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    input  logic                          s_tuser,
    input  logic [15:0]                   threshold,
    output logic                          push,
    output vfs_pkg::voxel_t               push_data,
    input  logic                          q_full
);
    import vfs_pkg::*;

    logic   stage_valid_reg;
    voxel_t stage_reg;
    voxel_t stage_next;
    logic   accept;

    // classify incoming word
    always_comb
    begin
        stage_next.density = s_tdata[31:0];
        stage_next.vel_x   = s_tdata[63:32];
        stage_next.vel_y   = s_tdata[95:64];
        stage_next.vel_z   = s_tdata[127:96];
        stage_next.solid   = s_tuser;
        stage_next.last    = s_tlast;
        stage_next.active  = !s_tdata[31] && (s_tdata[30:0] > 31'(threshold));
    end

    assign s_tready  = !stage_valid_reg || !q_full;
    assign accept    = s_tvalid && s_tready;
    assign push      = stage_valid_reg;
    assign push_data = stage_reg;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (!q_full)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

// ===== hdl/vfs_queue.sv =====
// ---------------------------------------------------------------------------
// vfs_queue: short fifo between front and back
// Holds classified voxels so that each side stalls on its own.
// ---------------------------------------------------------------------------
module vfs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  vfs_pkg::voxel_t push_data,
    output logic            full,
    input  logic            pop,
    output vfs_pkg::voxel_t head,
    output logic            empty
);
    import vfs_pkg::*;

    voxel_t             mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W:0]   cnt_reg;
    logic               do_push;
    logic               do_pop;

    assign full    = (cnt_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/vfs_iter.sv =====
// ---------------------------------------------------------------------------
// vfs_iter: shared iterative square root and divider
// Square root of a 64-bit value, one result bit a cycle, or 64 by 52-bit
// restoring division, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module vfs_iter (
    input  logic               clk,
    input  logic               rst_n,
    input  vfs_pkg::iter_req_t req,
    output logic               done,
    output logic [63:0]        result
);
    import vfs_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    iter_op_t              op_reg;
    logic [ITER_CNT_W-1:0] cnt_reg;
    logic [ITER_CNT_W-1:0] last_cnt;
    logic [63:0]           a_reg;
    logic [WT_W-1:0]       b_reg;
    logic [WT_W-1:0]       rem_reg;
    logic [63:0]           res_reg;
    logic [63:0]           bit_reg;
    logic [63:0]           trial;
    logic                  sq_ge;
    logic [WT_W:0]         div_t;
    logic                  div_ge;

    // one step of each operation
    always_comb
    begin
        trial  = res_reg + bit_reg;
        sq_ge  = (a_reg >= trial);
        div_t  = {rem_reg, a_reg[63]};
        div_ge = (div_t >= {1'b0, b_reg});
    end

    assign last_cnt = (op_reg == ITER_SQRT) ? ITER_CNT_W'(SQRT_STEPS-1)
                                            : ITER_CNT_W'(DIV_STEPS-1);
    assign done     = done_reg;
    assign result   = (op_reg == ITER_DIV) ? a_reg : res_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= ITER_SQRT;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                op_reg   <= req.op;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == last_cnt)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            rem_reg <= '0;
            res_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (op_reg == ITER_SQRT)
            begin
                if (sq_ge)
                begin
                    a_reg   <= a_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            else
            begin
                rem_reg <= div_ge ? WT_W'(div_t - {1'b0, b_reg}) : div_t[WT_W-1:0];
                a_reg   <= {a_reg[62:0], div_ge};
            end
        end
    end

endmodule

// ===== hdl/vfs_back.sv =====
// ---------------------------------------------------------------------------
// vfs_back: statistics sequencer
// Pops voxels, runs squares, projection and weighting through one shared
// multiplier, uses the iterative unit for roots and divisions, keeps the
// pass accumulators and holds the result word for the master stream.
// ---------------------------------------------------------------------------
module vfs_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  vfs_pkg::cfg_t                   cfg,
    input  vfs_pkg::voxel_t                 head,
    input  logic                            q_empty,
    output logic                            pop,
    output vfs_pkg::iter_req_t              iter_req,
    input  logic                            iter_done,
    input  logic [63:0]                     iter_result,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [vfs_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tuser
);
    import vfs_pkg::*;

    localparam logic signed [64:0] SUM_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SUM_MIN = -SUM_MAX;
    localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (FRAC_BITS-1);

    back_state_t state_reg, state_next;
    logic [1:0]  step_reg;
    logic        issued_reg;
    logic        it_done;

    voxel_t                   vox_reg;
    logic                     pass_open_reg;
    logic                     axis_ok_reg;
    logic signed [UNIT_W-1:0] unit_reg [3];
    logic [31:0]              len_reg;
    logic [CNT_W-1:0]         active_cnt_reg;
    logic [CNT_W-1:0]         solid_cnt_reg;
    logic [30:0]              max_dens_reg;
    logic [30:0]              max_mag_reg;
    logic signed [63:0]       ws_reg;
    logic [WT_W-1:0]          wt_reg;
    logic [30:0]              axis_peak_reg;
    logic signed [31:0]       mean_reg;
    logic signed [63:0]       prod_reg;
    logic [63:0]              acc_reg;
    logic signed [31:0]       p_reg;
    logic                     out_valid_reg;
    logic [OUT_TDATA_W-1:0]   out_data_reg;
    logic                     out_user_reg;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_out;
    logic signed [31:0] dir_sel;
    logic signed [31:0] vel_sel;
    logic signed [UNIT_W-1:0] unit_sel;
    logic               axis_len_ok;
    logic               out_free;
    logic               is_mul_state;
    logic               is_iter_state;

    logic signed [63:0] round_w;
    logic signed [63:0] round_sh;
    logic signed [64:0] ws_sum;
    logic [WT_W:0]      wt_sum;
    logic [63:0]        q_sat;
    logic [31:0]        speed;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    assign it_done      = issued_reg && iter_done;
    assign axis_len_ok  = cfg.up_enable && (iter_result[31:0] > 32'(cfg.threshold));
    assign out_free     = !out_valid_reg || m_tready;
    assign is_mul_state = (state_reg == BK_AX_MUL) || (state_reg == BK_V_MUL) ||
                          (state_reg == BK_P_MUL);
    assign is_iter_state = (state_reg == BK_AX_SQRT) || (state_reg == BK_AX_DIV) ||
                           (state_reg == BK_V_SQRT) || (state_reg == BK_M_DIV);

    // component select by step
    always_comb
    begin
        unique case (step_reg)
            2'd0:
            begin
                dir_sel  = cfg.up_dir_x;
                vel_sel  = vox_reg.vel_x;
                unit_sel = unit_reg[0];
            end
            2'd1:
            begin
                dir_sel  = cfg.up_dir_y;
                vel_sel  = vox_reg.vel_y;
                unit_sel = unit_reg[1];
            end
            default:
            begin
                dir_sel  = cfg.up_dir_z;
                vel_sel  = vox_reg.vel_z;
                unit_sel = unit_reg[2];
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
                if (!q_empty)
                begin
                    state_next = pass_open_reg ? BK_V_MUL : BK_AX_MUL;
                end
            BK_AX_MUL:
                if (step_reg == 2'd3)
                begin
                    state_next = BK_AX_SQRT;
                end
            BK_AX_SQRT:
                if (it_done)
                begin
                    state_next = axis_len_ok ? BK_AX_DIV : BK_V_MUL;
                end
            BK_AX_DIV:
                if (it_done && step_reg == 2'd2)
                begin
                    state_next = BK_V_MUL;
                end
            BK_V_MUL:
                if (step_reg == 2'd3)
                begin
                    state_next = BK_V_SQRT;
                end
            BK_V_SQRT:
                if (it_done)
                begin
                    state_next = (vox_reg.active && axis_ok_reg) ? BK_P_MUL : BK_END;
                end
            BK_P_MUL:
                if (step_reg == 2'd3)
                begin
                    state_next = BK_P_FIN;
                end
            BK_P_FIN:  state_next = BK_PD_MUL;
            BK_PD_MUL: state_next = BK_PD_ACC;
            BK_PD_ACC: state_next = BK_END;
            BK_END:
                if (!vox_reg.last)
                begin
                    state_next = BK_IDLE;
                end
                else if (axis_ok_reg && wt_reg != '0)
                begin
                    state_next = BK_M_DIV;
                end
                else
                begin
                    state_next = BK_EMIT;
                end
            BK_M_DIV:
                if (it_done)
                begin
                    state_next = BK_EMIT;
                end
            BK_EMIT:
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            default: state_next = BK_IDLE;
        endcase
    end

    // sequencer outputs: queue pop, multiplier operands, iterative unit request
    always_comb
    begin
        pop          = 1'b0;
        mul_a        = vel_sel;
        mul_b        = vel_sel;
        iter_req.start = is_iter_state && !issued_reg;
        iter_req.op    = ITER_SQRT;
        iter_req.a     = acc_reg;
        iter_req.b     = wt_reg;
        unique case (state_reg)
            BK_IDLE:   pop = !q_empty;
            BK_AX_MUL:
            begin
                mul_a = dir_sel;
                mul_b = dir_sel;
            end
            BK_P_MUL:  mul_b = 32'(unit_sel);
            BK_PD_MUL:
            begin
                mul_a = p_reg;
                mul_b = vox_reg.density;
            end
            BK_AX_DIV:
            begin
                iter_req.op = ITER_DIV;
                iter_req.a  = (64'(mag32(dir_sel)) << FRAC_BITS) + 64'(len_reg >> 1);
                iter_req.b  = WT_W'(len_reg);
            end
            BK_M_DIV:
            begin
                iter_req.op = ITER_DIV;
                iter_req.a  = (ws_reg[63] ? 64'(-ws_reg) : 64'(ws_reg)) + 64'(wt_reg >> 1);
                iter_req.b  = wt_reg;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    assign mul_out = mul_a * mul_b;

    // rounding, saturation and accumulation terms
    always_comb
    begin
        round_w  = $signed(acc_reg) + HALF_LSB;
        round_sh = round_w >>> FRAC_BITS;
        ws_sum   = 65'(ws_reg) + 65'(prod_reg);
        wt_sum   = {1'b0, wt_reg} + (WT_W+1)'(vox_reg.density[30:0]);
        speed    = iter_result[31:0];
        if (ws_reg[63])
        begin
            q_sat = (iter_result > 64'h8000_0000) ? 64'h8000_0000 : iter_result;
        end
        else
        begin
            q_sat = (iter_result > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : iter_result;
        end
    end

    // sequencer and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            step_reg       <= '0;
            issued_reg     <= 1'b0;
            pass_open_reg  <= 1'b0;
            axis_ok_reg    <= 1'b0;
            unit_reg[0]    <= '0;
            unit_reg[1]    <= '0;
            unit_reg[2]    <= '0;
            active_cnt_reg <= '0;
            solid_cnt_reg  <= '0;
            max_dens_reg   <= '0;
            max_mag_reg    <= '0;
            ws_reg         <= '0;
            wt_reg         <= '0;
            axis_peak_reg  <= '0;
            mean_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // step and issue tracking
            if (state_next != state_reg)
            begin
                step_reg   <= '0;
                issued_reg <= 1'b0;
            end
            else
            begin
                if (is_mul_state)
                begin
                    step_reg <= step_reg + 1'b1;
                end
                if (iter_req.start)
                begin
                    issued_reg <= 1'b1;
                end
                if (it_done)
                begin
                    issued_reg <= 1'b0;
                    step_reg   <= step_reg + 1'b1;
                end
            end

            // result word valid: loaded on emit, cleared when taken
            if (state_reg == BK_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                BK_IDLE:
                    if (!q_empty)
                    begin
                        if (head.solid && solid_cnt_reg < COUNT_CAP)
                        begin
                            solid_cnt_reg <= solid_cnt_reg + 1'b1;
                        end
                        if (head.active && active_cnt_reg < COUNT_CAP)
                        begin
                            active_cnt_reg <= active_cnt_reg + 1'b1;
                        end
                        if (!head.density[31] && head.density[30:0] > max_dens_reg)
                        begin
                            max_dens_reg <= head.density[30:0];
                        end
                    end
                BK_AX_SQRT:
                    if (it_done)
                    begin
                        pass_open_reg <= 1'b1;
                        axis_ok_reg   <= 1'b0;
                        if (!axis_len_ok)
                        begin
                            unit_reg[0] <= '0;
                            unit_reg[1] <= '0;
                            unit_reg[2] <= '0;
                        end
                    end
                BK_AX_DIV:
                    if (it_done)
                    begin
                        unit_reg[step_reg] <= dir_sel[31] ? -UNIT_W'(iter_result)
                                                          : UNIT_W'(iter_result);
                        if (step_reg == 2'd2)
                        begin
                            axis_ok_reg <= 1'b1;
                        end
                    end
                BK_V_SQRT:
                    if (it_done)
                    begin
                        if (speed[31])
                        begin
                            max_mag_reg <= 31'h7FFF_FFFF;
                        end
                        else if (speed[30:0] > max_mag_reg)
                        begin
                            max_mag_reg <= speed[30:0];
                        end
                    end
                BK_PD_ACC:
                begin
                    if (ws_sum > SUM_MAX)
                    begin
                        ws_reg <= SUM_MAX[63:0];
                    end
                    else if (ws_sum < SUM_MIN)
                    begin
                        ws_reg <= SUM_MIN[63:0];
                    end
                    else
                    begin
                        ws_reg <= ws_sum[63:0];
                    end
                    wt_reg <= (wt_sum > {1'b0, WT_CAP}) ? WT_CAP : wt_sum[WT_W-1:0];
                    if (!p_reg[31] && p_reg[30:0] > axis_peak_reg)
                    begin
                        axis_peak_reg <= p_reg[30:0];
                    end
                end
                BK_END:
                    mean_reg <= '0;
                BK_M_DIV:
                    if (it_done)
                    begin
                        mean_reg <= ws_reg[63] ? 32'(~q_sat + 64'd1) : 32'(q_sat);
                    end
                BK_EMIT:
                    if (out_free)
                    begin
                        pass_open_reg  <= 1'b0;
                        active_cnt_reg <= '0;
                        solid_cnt_reg  <= '0;
                        max_dens_reg   <= '0;
                        max_mag_reg    <= '0;
                        ws_reg         <= '0;
                        wt_reg         <= '0;
                        axis_peak_reg  <= '0;
                    end
                default: ;
            endcase
        end
    end

    // multiplier pipeline, sums and result word
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_out;
        if (state_reg == BK_IDLE && !q_empty)
        begin
            vox_reg <= head;
        end
        if (is_mul_state && step_reg != 2'd0)
        begin
            acc_reg <= ((step_reg == 2'd1) ? 64'd0 : acc_reg) + 64'(prod_reg);
        end
        if (state_reg == BK_AX_SQRT && it_done)
        begin
            len_reg <= iter_result[31:0];
        end
        if (state_reg == BK_P_FIN)
        begin
            if (round_sh > 64'sh7FFF_FFFF)
            begin
                p_reg <= 32'sh7FFF_FFFF;
            end
            else if (round_sh < -64'sh8000_0000)
            begin
                p_reg <= 32'sh8000_0000;
            end
            else
            begin
                p_reg <= round_sh[31:0];
            end
        end
        if (state_reg == BK_EMIT && out_free)
        begin
            out_data_reg <= {7'd0,
                             axis_ok_reg ? axis_peak_reg : 31'd0,
                             mean_reg,
                             max_mag_reg,
                             max_dens_reg,
                             solid_cnt_reg,
                             active_cnt_reg};
            out_user_reg <= axis_ok_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ===== hdl/volume_flow_statistics_unit.sv =====
// ---------------------------------------------------------------------------
// volume_flow_statistics_unit: volume flow statistics, top level
// Reduces a voxel stream to counts, peaks and an up-axis weighted mean.
//
//  channel | direction | handshake          | content
//  s_*     | in        | s_tvalid/s_tready  | voxel word, tuser solid, tlast end of pass
//  m_*     | out       | m_tvalid/m_tready  | statistics word, tuser axis valid
//  cfg_*   | in        | cfg_valid/cfg_ready| register index and write data
//
// A voxel's time in the back end is set by the shared one-bit-a-cycle root/divide
// unit and is longer when the voxel is active and the axis is valid. The first voxel
// of a pass adds the axis normalization, the last adds the mean division. Front and
// back are parted by a two-word queue; a waiting result word does not stop the next
// voxel.
// Reset clears all pass state; no clearing pass is needed.
// ---------------------------------------------------------------------------
module volume_flow_statistics_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // s_tdata: cell_density, cell_vel_x, cell_vel_y, cell_vel_z
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [vfs_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tlast,
    // s_tuser: cell_solid
    input  logic                            s_tuser,
    // m_tdata: active_cells, solid_cells, peak_density, peak_speed, up_mean, up_peak
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [vfs_pkg::OUT_TDATA_W-1:0] m_tdata,
    // m_tuser: up_stats_valid
    output logic                            m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [vfs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);
    import vfs_pkg::*;

    cfg_t      cfg_reg;
    logic      push;
    voxel_t    push_data;
    logic      q_full;
    logic      q_empty;
    logic      pop;
    voxel_t    head;
    iter_req_t iter_req;
    logic      iter_done;
    logic [63:0] iter_result;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.up_enable <= 1'b0;
            cfg_reg.up_dir_x  <= '0;
            cfg_reg.up_dir_y  <= '0;
            cfg_reg.up_dir_z  <= '0;
            cfg_reg.threshold <= 16'd7;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_UP_ENABLE: cfg_reg.up_enable <= cfg_data[0];
                CFG_UP_DIR_X:  cfg_reg.up_dir_x  <= cfg_data;
                CFG_UP_DIR_Y:  cfg_reg.up_dir_y  <= cfg_data;
                CFG_UP_DIR_Z:  cfg_reg.up_dir_z  <= cfg_data;
                CFG_THRESHOLD: cfg_reg.threshold <= cfg_data[15:0];
                default:       cfg_reg.up_enable <= cfg_reg.up_enable;
            endcase
        end
    end

    vfs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .threshold (cfg_reg.threshold),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    vfs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty)
    );

    vfs_iter u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (iter_req),
        .done   (iter_done),
        .result (iter_result)
    );

    vfs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head        (head),
        .q_empty     (q_empty),
        .pop         (pop),
        .iter_req    (iter_req),
        .iter_done   (iter_done),
        .iter_result (iter_result),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

// ===== hdl/vfs_checker.sv =====
// ---------------------------------------------------------------------------
// vfs_checker: port checks of the statistics unit
// Watches the master stream for hold, padding and axis gating behavior.
// ---------------------------------------------------------------------------
module vfs_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [vfs_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            m_tuser
);

    // stalled word stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // stalled word keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // no axis means zero mean and zero axis peak
    a_axis_gate: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[168:106] == '0)
        else $error("axis statistics nonzero without valid axis");

    // padding bits stay clear
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[175:169] == '0)
        else $error("padding bits set in result word");

endmodule

bind volume_flow_statistics_unit vfs_checker u_vfs_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: volume flow statistics unit testbench
// Streams voxel passes through the unit under several register settings,
// predicts each pass result from its own model of the reduction and checks
// every result word field by field, with bursty input and a stalling sink.
// ---------------------------------------------------------------------------
import vfs_pkg::*;

typedef struct {
    logic [21:0] act;
    logic [21:0] sol;
    logic [30:0] pk_dens;
    logic [30:0] pk_speed;
    logic        axis_valid;
    logic [31:0] mean;
    logic [30:0] pk_up;
} pass_stats_t;

class flow_scoreboard;
    // register copy
    bit                 up_en;
    logic signed [31:0] dir [3];
    logic [15:0]        thr;
    // pass state
    longint             unit [3];
    bit                 axis_ok;
    bit                 pass_open;
    int unsigned        act_cnt, sol_cnt;
    longint             max_dens, max_mag, axis_pk;
    longint             wsum;
    longint unsigned    wtot;
    pass_stats_t        pending [$];
    int                 errors;

    function new();
        up_en = 0;
        dir[0] = 0; dir[1] = 0; dir[2] = 0;
        thr = 7;
        axis_ok = 0;
        unit[0] = 0; unit[1] = 0; unit[2] = 0;
        errors = 0;
        clear_pass();
    endfunction

    function void clear_pass();
        act_cnt = 0; sol_cnt = 0;
        max_dens = 0; max_mag = 0; axis_pk = 0;
        wsum = 0; wtot = 0;
        pass_open = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        case (idx)
            CFG_UP_ENABLE: up_en = val[0];
            CFG_UP_DIR_X:  dir[0] = val;
            CFG_UP_DIR_Y:  dir[1] = val;
            CFG_UP_DIR_Z:  dir[2] = val;
            CFG_THRESHOLD: thr = val[15:0];
            default: ;
        endcase
    endfunction

    function longint unsigned root64(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function longint unsigned magn(longint v);
        return v < 0 ? -v : v;
    endfunction

    function longint unsigned norm3(longint a, longint b, longint c);
        return root64(magn(a) * magn(a) + magn(b) * magn(b) + magn(c) * magn(c));
    endfunction

    // normalize the up direction at the start of a pass
    function void latch_axis();
        longint unsigned len, q;
        axis_ok = 0;
        for (int i = 0; i < 3; i++) unit[i] = 0;
        if (!up_en) return;
        len = norm3(dir[0], dir[1], dir[2]);
        if (len <= thr) return;
        for (int i = 0; i < 3; i++) begin
            q = ((magn(dir[i]) << FRAC_BITS) + len / 2) / len;
            unit[i] = dir[i] < 0 ? -longint'(q) : longint'(q);
        end
        axis_ok = 1;
    endfunction

    function int unsigned bump(int unsigned c);
        return c < CNT_LIMIT ? c + 1 : CNT_LIMIT;
    endfunction

    // accepted voxel word
    function void note_voxel(logic signed [31:0] d, logic signed [31:0] vx,
                             logic signed [31:0] vy, logic signed [31:0] vz,
                             bit solid, bit last);
        longint unsigned spd, m, q;
        longint p, pd, mean;
        pass_stats_t r;
        if (!pass_open) begin
            latch_axis();
            pass_open = 1;
        end
        if (solid) sol_cnt = bump(sol_cnt);
        if (d > max_dens) max_dens = d;
        spd = norm3(vx, vy, vz);
        if (spd > 64'h7FFF_FFFF) spd = 64'h7FFF_FFFF;
        if (spd > max_mag) max_mag = spd;
        if (d > longint'(thr)) begin
            act_cnt = bump(act_cnt);
            if (axis_ok) begin
                p = (longint'(vx) * unit[0] + longint'(vy) * unit[1]
                     + longint'(vz) * unit[2] + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
                if (p > 64'sh7FFF_FFFF) p = 64'sh7FFF_FFFF;
                if (p < -64'sh8000_0000) p = -64'sh8000_0000;
                pd = p * longint'(d);
                if (pd > 0 && wsum > 64'sh7FFF_FFFF_FFFF_FFFF - pd)
                    wsum = 64'sh7FFF_FFFF_FFFF_FFFF;
                else if (pd < 0 && wsum < -64'sh7FFF_FFFF_FFFF_FFFF - pd)
                    wsum = -64'sh7FFF_FFFF_FFFF_FFFF;
                else
                    wsum = wsum + pd;
                wtot = wtot + longint'(d);
                if (wtot > WT_CAP) wtot = WT_CAP;
                if (p > axis_pk) axis_pk = p;
            end
        end
        if (!last) return;
        mean = 0;
        if (axis_ok && wtot > 0) begin
            m = magn(wsum);
            q = (m + wtot / 2) / wtot;
            if (wsum < 0) begin
                if (q > 64'h8000_0000) q = 64'h8000_0000;
                mean = -longint'(q);
            end
            else begin
                if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
                mean = q;
            end
        end
        r.act = 22'(act_cnt);
        r.sol = 22'(sol_cnt);
        r.pk_dens = 31'(max_dens);
        r.pk_speed = 31'(max_mag);
        r.axis_valid = axis_ok;
        r.mean = 32'(mean);
        r.pk_up = axis_ok ? 31'(axis_pk) : 31'd0;
        pending.push_back(r);
        clear_pass();
    endfunction

    function void fail(string what, longint e, longint a);
        errors++;
        if (errors <= 10)
            $display("mismatch %s: expected %0h actual %0h", what, e, a);
    endfunction

    // result word from the unit
    function void check_result(logic [OUT_TDATA_W-1:0] w, logic axis_flag);
        pass_stats_t e;
        if (pending.size() == 0) begin
            fail("unexpected result word", 0, w[63:0]);
            return;
        end
        e = pending.pop_front();
        if (w[21:0] != e.act) fail("active_cells", e.act, w[21:0]);
        if (w[43:22] != e.sol) fail("solid_cells", e.sol, w[43:22]);
        if (w[74:44] != e.pk_dens) fail("peak_density", e.pk_dens, w[74:44]);
        if (w[105:75] != e.pk_speed) fail("peak_speed", e.pk_speed, w[105:75]);
        if (axis_flag != e.axis_valid) fail("up_stats_valid", e.axis_valid, axis_flag);
        if (w[137:106] != e.mean) fail("up_mean", e.mean, w[137:106]);
        if (w[168:138] != e.pk_up) fail("up_peak", e.pk_up, w[168:138]);
        if (w[175:169] != 0) fail("padding", 0, w[175:169]);
    endfunction
endclass

module tb_top;
    logic                   clk = 0;
    logic                   rst_n = 0;
    logic                   s_tvalid = 0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tlast = 0;
    logic                   s_tuser = 0;
    logic                   m_tvalid;
    logic                   m_tready = 0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid = 0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [31:0]            cfg_data = '0;

    flow_scoreboard sb = new();
    int  burst_left = 0;
    bit  sink_hold = 0;

    volume_flow_statistics_unit uut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // register write, only while the unit is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic set_regs(bit en, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [15:0] th);
        write_reg(CFG_UP_ENABLE, en);
        write_reg(CFG_UP_DIR_X, x);
        write_reg(CFG_UP_DIR_Y, y);
        write_reg(CFG_UP_DIR_Z, z);
        write_reg(CFG_THRESHOLD, th);
    endtask

    // one voxel word, bursts with random gaps in between
    task automatic send_voxel(logic [31:0] d, logic [31:0] vx, logic [31:0] vy,
                              logic [31:0] vz, bit solid, bit last);
        if (burst_left == 0) begin
            s_tvalid = 0;
            repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 60)) @(negedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tdata = {vz, vy, vx, d};
        s_tuser = solid;
        s_tlast = last;
        s_tvalid = 1;
        do @(posedge clk); while (!s_tready);
        sb.note_voxel(d, vx, vy, vz, solid, last);
        @(negedge clk);
    endtask

    // wait for every pass result, then let the unit settle
    task automatic drain();
        s_tvalid = 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 20);
            2: return -$urandom_range(0, 20);
            3: return $urandom_range(0, 32'h0004_0000);
            4: return -$urandom_range(0, 32'h0004_0000);
            default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_dens(logic [15:0] th);
        case ($urandom_range(0, 4))
            0: return th + $urandom_range(0, 2) - 1;
            1: return $urandom;
            2: return -$urandom_range(0, 1000);
            default: return $urandom_range(0, 32'h0010_0000);
        endcase
    endfunction

    task automatic random_passes(int count);
        int n;
        while (count > 0) begin
            n = $urandom_range(0, 9) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                send_voxel(rand_dens(sb.thr), rand_val(), rand_val(), rand_val(),
                           $urandom_range(0, 1), i == n - 1);
            count -= n;
        end
    endtask

    // sink stall pattern
    initial
    begin
        int k;
        k = 0;
        forever
        begin
            @(negedge clk);
            k++;
            if (sink_hold)
                m_tready = 0;
            else if ((k / 300) % 3 == 0)
                m_tready = 1;
            else
                m_tready = $urandom_range(0, 3) != 0;
        end
    end

    // long sink hold-off while the source keeps offering voxels
    initial
    begin
        @(posedge rst_n);
        repeat (20000) @(negedge clk);
        sink_hold = 1;
        repeat (6000) @(negedge clk);
        sink_hold = 0;
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);

    initial
    begin
        #30ms;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // reset settings: threshold edges, density extremes, speed saturation
        send_voxel(32'd7, 32'd0, 32'd0, 32'd0, 0, 0);
        send_voxel(32'd8, 32'd3, 32'd4, 32'd0, 1, 0);
        send_voxel(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 0);
        send_voxel(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1);
        send_voxel(-32'sd5, 32'd1, 32'd1, 32'd1, 0, 1);
        drain();

        // axis along y: projection and weighted sum saturation, both signs
        set_regs(1, 32'd0, 32'h0001_0000, 32'd0, 16'd7);
        send_voxel(32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'd0, 0, 0);
        send_voxel(32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'd0, 0, 0);
        send_voxel(32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'd0, 0, 1);
        send_voxel(32'h7FFF_FFFF, 32'd0, 32'h8000_0000, 32'd0, 0, 0);
        send_voxel(32'h7FFF_FFFF, 32'd0, 32'h8000_0000, 32'd0, 0, 1);
        send_voxel(32'd3, 32'd5, 32'd5, 32'd5, 0, 1);
        send_voxel(32'h0001_0000, 32'h0000_8000, 32'hFFFF_8000, 32'h1234, 1, 1);
        drain();

        // oblique huge axis, no threshold
        set_regs(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0);
        send_voxel(32'd1, 32'd100, -32'sd100, 32'd7, 0, 0);
        send_voxel(32'd0, 32'd1, 32'd1, 32'd1, 1, 1);
        drain();

        // axis too short for the threshold, then disabled axis
        set_regs(1, 32'd3, 32'd4, 32'd0, 16'hFFFF);
        send_voxel(32'h0002_0000, 32'd9, 32'd9, 32'd9, 0, 1);
        drain();
        set_regs(0, 32'h0001_0000, 32'd0, 32'd0, 16'd7);
        send_voxel(32'h0002_0000, 32'd9, 32'd9, 32'd9, 0, 1);
        drain();

        // random settings, extremes among them
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: set_regs(1, $urandom, $urandom, $urandom, 16'd0);
                1: set_regs(1, rand_val(), rand_val(), rand_val(), 16'hFFFF);
                2: set_regs(0, $urandom, $urandom, $urandom, $urandom);
                default: set_regs($urandom_range(0, 3) != 0, rand_val(), rand_val(),
                                  rand_val(), $urandom_range(0, 1) ? $urandom : $urandom_range(0, 16));
            endcase
            random_passes(ph == 0 ? 200 : 115);
            drain();
        end

        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/vfs_pkg.sv
hdl/vfs_front.sv
hdl/vfs_queue.sv
hdl/vfs_iter.sv
hdl/vfs_back.sv
hdl/volume_flow_statistics_unit.sv
hdl/vfs_checker.sv
tb/tb_top.sv
